FILE: src/assert_macros.svh
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, checked at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tcw_pkg.sv
// Types and constants of the text console character writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int TAB_STOP = 8;

  // item opcodes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_BACKGROUND = 1'd0;
  localparam logic [0:0] REG_FOREGROUND = 1'd1;

  // control bytes and fill words
  localparam logic [7:0]  CH_BS        = 8'h08;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [15:0] SCROLL_BLANK = 16'h0F20;

  localparam logic [COLOR_W-1:0] BACKGROUND_RST = 4'd1;
  localparam logic [COLOR_W-1:0] FOREGROUND_RST = 4'd15;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_data;
    logic                scrolled;
  } out_item_t;

endpackage

FILE: src/text_console_char_writer_unit.sv
// Text console character writer: microcoded sequencer over a COLUMNS x ROWS cell store.
// One item at a time. A put that scrolls moves the rows up, one cell copied per cycle
// through the store's single read and write port. A clear fills the store, one cell
// written per cycle. A new item is taken while the previous result waits in the output
// register. Reset (synchronous) homes the cursor, restores colors 1/15 and restarts the
// sequencer; the cell store keeps its contents.
module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcw_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcw_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  `include "assert_macros.svh"

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int CW        = $clog2(COLUMNS + TAB_STOP);
  localparam int POS_XW    = (ADDR_W > CURSOR_W) ? ADDR_W : CURSOR_W;
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  // microcode fields
  localparam int PC_W = 4;

  localparam logic [3:0] A_NOP        = 4'd0;
  localparam logic [3:0] A_ACCEPT     = 4'd1;
  localparam logic [3:0] A_PUT        = 4'd2;
  localparam logic [3:0] A_SCR_INIT   = 4'd3;
  localparam logic [3:0] A_COPY       = 4'd4;
  localparam logic [3:0] A_BOTTOM     = 4'd5;
  localparam logic [3:0] A_FILL_BLANK = 4'd6;
  localparam logic [3:0] A_CLR_INIT   = 4'd7;
  localparam logic [3:0] A_FILL_CLEAR = 4'd8;
  localparam logic [3:0] A_READ       = 4'd9;
  localparam logic [3:0] A_EMIT       = 4'd10;

  localparam logic [2:0] C_NEXT         = 3'd0;
  localparam logic [2:0] C_ALWAYS       = 3'd1;
  localparam logic [2:0] C_FUNC_CLEAR   = 3'd2;
  localparam logic [2:0] C_FUNC_READ    = 3'd3;
  localparam logic [2:0] C_FUNC_NOT_PUT = 3'd4;
  localparam logic [2:0] C_NO_SCROLL    = 3'd5;
  localparam logic [2:0] C_SWEEP_MORE   = 3'd6;

  // program steps
  localparam logic [PC_W-1:0] PC_FETCH      = 4'd0;
  localparam logic [PC_W-1:0] PC_DISP_CLR   = 4'd1;
  localparam logic [PC_W-1:0] PC_DISP_READ  = 4'd2;
  localparam logic [PC_W-1:0] PC_DISP_PUT   = 4'd3;
  localparam logic [PC_W-1:0] PC_PUT        = 4'd4;
  localparam logic [PC_W-1:0] PC_SCR_INIT   = 4'd5;
  localparam logic [PC_W-1:0] PC_SCR_COPY   = 4'd6;
  localparam logic [PC_W-1:0] PC_SCR_BOTTOM = 4'd7;
  localparam logic [PC_W-1:0] PC_SCR_FILL   = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT       = 4'd9;
  localparam logic [PC_W-1:0] PC_CLR_INIT   = 4'd10;
  localparam logic [PC_W-1:0] PC_CLR_FILL   = 4'd11;
  localparam logic [PC_W-1:0] PC_CLR_DONE   = 4'd12;
  localparam logic [PC_W-1:0] PC_RD_ISSUE   = 4'd13;

  typedef struct packed {
    logic [3:0]      act;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    begin
      unique case (pc)
        PC_FETCH:      w = '{A_ACCEPT,     C_NEXT,         PC_FETCH};
        PC_DISP_CLR:   w = '{A_NOP,        C_FUNC_CLEAR,   PC_CLR_INIT};
        PC_DISP_READ:  w = '{A_NOP,        C_FUNC_READ,    PC_RD_ISSUE};
        PC_DISP_PUT:   w = '{A_NOP,        C_FUNC_NOT_PUT, PC_EMIT};
        PC_PUT:        w = '{A_PUT,        C_NO_SCROLL,    PC_EMIT};
        PC_SCR_INIT:   w = '{A_SCR_INIT,   C_NEXT,         PC_FETCH};
        PC_SCR_COPY:   w = '{A_COPY,       C_SWEEP_MORE,   PC_SCR_COPY};
        PC_SCR_BOTTOM: w = '{A_BOTTOM,     C_NEXT,         PC_FETCH};
        PC_SCR_FILL:   w = '{A_FILL_BLANK, C_SWEEP_MORE,   PC_SCR_FILL};
        PC_EMIT:       w = '{A_EMIT,       C_ALWAYS,       PC_FETCH};
        PC_CLR_INIT:   w = '{A_CLR_INIT,   C_NEXT,         PC_FETCH};
        PC_CLR_FILL:   w = '{A_FILL_CLEAR, C_SWEEP_MORE,   PC_CLR_FILL};
        PC_CLR_DONE:   w = '{A_NOP,        C_ALWAYS,       PC_EMIT};
        PC_RD_ISSUE:   w = '{A_READ,       C_ALWAYS,       PC_EMIT};
        default:       w = '{A_NOP,        C_ALWAYS,       PC_FETCH};
      endcase
      return w;
    end
  endfunction

  // control state
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]  rowbase_r, rowbase_nxt;   // cursor_row * COLUMNS
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic               copy_pend_r, copy_pend_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]  copy_dst_r, copy_dst_nxt;
  logic [1:0]         func_r, func_nxt;
  logic [7:0]         char_r, char_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               read_ok_r, read_ok_nxt;
  out_item_t          out_r, out_nxt;

  // cell store
  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  mem_rdata_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata;

  ctrl_t              uc;
  logic               stall, jump;
  logic [CW-1:0]      col_ext, tab_col, put_col;
  logic               put_adv, put_we, put_scroll;
  logic [POS_XW-1:0]  cur_pos_x;
  logic               cursor_in_grid, store_write_busy, emit_scrolled;

  assign uc      = ucode(pc_r);
  assign col_ext = CW'(col_r);
  assign tab_col = (col_ext + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);

  // cursor update for one put byte
  always_comb begin
    put_col = col_ext;
    put_adv = 1'b0;
    put_we  = 1'b0;
    case (char_r)
      CH_BS:  if (col_r != '0) put_col = col_ext - CW'(1);
      CH_TAB: put_col = tab_col;
      CH_CR:  put_col = '0;
      CH_LF: begin
        put_col = '0;
        put_adv = 1'b1;
      end
      default: begin
        if (char_r >= CH_SPACE && !char_r[7]) begin
          put_we  = 1'b1;
          put_col = col_ext + CW'(1);
        end
      end
    endcase
    if (put_col >= CW'(COLUMNS)) begin
      put_col = '0;
      put_adv = 1'b1;
    end
    put_scroll = put_adv && (rowbase_r == LAST_BASE);
  end

  assign stall = ((uc.act == A_ACCEPT) && !in_valid) ||
                 ((uc.act == A_EMIT) && out_valid_r && !out_ready);

  always_comb begin
    unique case (uc.cond)
      C_NEXT:         jump = 1'b0;
      C_ALWAYS:       jump = 1'b1;
      C_FUNC_CLEAR:   jump = (func_r == FUNC_CLEAR);
      C_FUNC_READ:    jump = (func_r == FUNC_READ);
      C_FUNC_NOT_PUT: jump = (func_r != FUNC_PUT);
      C_NO_SCROLL:    jump = !put_scroll;
      C_SWEEP_MORE:   jump = (ptr_r != LAST_CELL);
      default:        jump = 1'b0;
    endcase
  end

  assign cur_pos_x = POS_XW'(rowbase_r) + POS_XW'(col_r);

  always_comb begin
    pc_nxt        = stall ? pc_r : (jump ? uc.target : pc_r + PC_W'(1));
    col_nxt       = col_r;
    rowbase_nxt   = rowbase_r;
    bg_nxt        = bg_r;
    fg_nxt        = fg_r;
    scrolled_nxt  = scrolled_r;
    copy_pend_nxt = (uc.act == A_COPY);
    out_valid_nxt = out_valid_r && !out_ready;
    ptr_nxt       = ptr_r;
    copy_dst_nxt  = copy_dst_r;
    func_nxt      = func_r;
    char_nxt      = char_r;
    rd_addr_nxt   = rd_addr_r;
    read_ok_nxt   = read_ok_r;
    out_nxt       = out_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;

    if (cfg_we) begin
      if (cfg_index == REG_BACKGROUND) bg_nxt = cfg_data;
      if (cfg_index == REG_FOREGROUND) fg_nxt = cfg_data;
    end

    unique case (uc.act)
      A_NOP: ;
      A_ACCEPT: begin
        if (in_valid) begin
          func_nxt     = in_data.func;
          char_nxt     = in_data.char_code;
          rd_addr_nxt  = ADDR_W'(in_data.read_addr);
          read_ok_nxt  = (32'(in_data.read_addr) < CELLS);
          scrolled_nxt = 1'b0;
        end
      end
      A_PUT: begin
        col_nxt = COL_W'(put_col);
        if (put_adv && !put_scroll) rowbase_nxt = rowbase_r + ROW_STEP;
      end
      A_SCR_INIT: begin
        ptr_nxt      = ROW_STEP;
        scrolled_nxt = 1'b1;
      end
      A_COPY: begin
        // read cell ptr now, write it one row up next cycle
        mem_re       = 1'b1;
        copy_dst_nxt = ptr_r - ROW_STEP;
        ptr_nxt      = ptr_r + ADDR_W'(1);
      end
      A_BOTTOM:     ptr_nxt = LAST_BASE;
      A_FILL_BLANK: ptr_nxt = ptr_r + ADDR_W'(1);
      A_CLR_INIT: begin
        ptr_nxt     = '0;
        col_nxt     = '0;
        rowbase_nxt = '0;
      end
      A_FILL_CLEAR: ptr_nxt = ptr_r + ADDR_W'(1);
      A_READ: begin
        mem_re    = read_ok_r;
        mem_raddr = rd_addr_r;
      end
      A_EMIT: begin
        if (!stall) begin
          out_valid_nxt      = 1'b1;
          out_nxt.cursor_pos = cur_pos_x[CURSOR_W-1:0];
          out_nxt.cell_data  = (func_r == FUNC_READ && read_ok_r) ? mem_rdata_r : '0;
          out_nxt.scrolled   = scrolled_r;
        end
      end
      default: ;
    endcase
  end

  // single write port: a pending copy write wins (no fill or put step overlaps it)
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = {bg_r, fg_r, CH_SPACE};
    if (copy_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = copy_dst_r;
      mem_wdata = mem_rdata_r;
    end else begin
      case (uc.act)
        A_PUT: begin
          mem_we    = put_we;
          mem_waddr = rowbase_r + ADDR_W'(col_r);
          mem_wdata = {bg_r, fg_r, char_r};
        end
        A_FILL_BLANK: begin
          mem_we    = 1'b1;
          mem_wdata = SCROLL_BLANK;
        end
        A_FILL_CLEAR: mem_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_FETCH;
      col_r       <= '0;
      rowbase_r   <= '0;
      bg_r        <= BACKGROUND_RST;
      fg_r        <= FOREGROUND_RST;
      scrolled_r  <= 1'b0;
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      col_r       <= col_nxt;
      rowbase_r   <= rowbase_nxt;
      bg_r        <= bg_nxt;
      fg_r        <= fg_nxt;
      scrolled_r  <= scrolled_nxt;
      copy_pend_r <= copy_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    copy_dst_r <= copy_dst_nxt;
    func_r     <= func_nxt;
    char_r     <= char_nxt;
    rd_addr_r  <= rd_addr_nxt;
    read_ok_r  <= read_ok_nxt;
    out_r      <= out_nxt;
  end

  assign in_ready  = (uc.act == A_ACCEPT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cursor_in_grid   = (32'(col_r) < COLUMNS) && (rowbase_r <= LAST_BASE);
  assign store_write_busy = (uc.act == A_PUT) || (uc.act == A_FILL_BLANK) ||
                            (uc.act == A_FILL_CLEAR);
  assign emit_scrolled    = scrolled_r && (pc_r == PC_EMIT);

  `TCW_ASSERT_ALWAYS(a_cursor_in_grid, cursor_in_grid, "cursor outside grid")
  `TCW_ASSERT_IMPL(a_copy_write_alone, copy_pend_r, !store_write_busy, "store write collision")
  `TCW_ASSERT_NEXT(a_item_leaves_fetch, in_valid && in_ready, pc_r != PC_FETCH, "item stuck")
  `TCW_ASSERT_IMPL(a_scroll_only_on_put, emit_scrolled, func_r == FUNC_PUT, "scroll on non-put")

endmodule
